@@ hdl/spmf_pkg.sv @@
package spmf_pkg;

    // operation codes of an input item
    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_UNUSED = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    localparam int HANDLE_W   = 16;
    localparam int LEVEL_W    = 3;
    localparam int CFG_W      = 4;
    localparam int HELD_W     = 8;

endpackage

@@ hdl/spmf_ctrl.sv @@
module spmf_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  spmf_pkg::dp_status_t   dp_status,
    output spmf_pkg::ctrl_cmd_t    cmd
);

    spmf_pkg::ctrl_state_t state_reg;
    spmf_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spmf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.accept   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            spmf_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = spmf_pkg::ST_RESP;
                end
            end
            spmf_pkg::ST_RESP: begin
                // wait for a free output slot
                if (dp_status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = spmf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spmf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/spmf_datapath.sv @@
module spmf_datapath #(
    parameter int LEVELS      = 8,
    parameter int LEVEL_DEPTH = 16,
    parameter int HANDLE_BITS = 16,
    parameter int LIW         = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [LIW-1:0]                      levels_in_use,
    input  spmf_pkg::ctrl_cmd_t                 cmd,
    output spmf_pkg::dp_status_t                dp_status,
    input  logic                                s_operation,
    input  logic [spmf_pkg::HANDLE_W-1:0]       s_item_handle,
    input  logic [spmf_pkg::LEVEL_W-1:0]        s_priority_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [spmf_pkg::HANDLE_W-1:0]       m_served_handle,
    output logic [spmf_pkg::LEVEL_W-1:0]        m_served_level,
    output logic                                m_queue_empty,
    output logic [spmf_pkg::HELD_W-1:0]         m_held_count
);

    localparam int SW    = (HANDLE_BITS < spmf_pkg::HANDLE_W) ? HANDLE_BITS
                                                              : spmf_pkg::HANDLE_W;
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PW    = $clog2(LEVEL_DEPTH);
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int DEPTH = LEVELS * LEVEL_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int TXW   = (TW > spmf_pkg::HELD_W) ? TW : spmf_pkg::HELD_W;

    // per-level ring state
    logic [PW-1:0] head_reg  [LEVELS];
    logic [PW-1:0] tail_reg  [LEVELS];
    logic [CW-1:0] count_reg [LEVELS];
    logic [TW-1:0] total_reg;

    // handle store and its registered read port
    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] rdata_reg;

    // result waiting for the store read
    spmf_pkg::status_t             pend_status_reg;
    logic                          pend_hit_reg;
    logic [spmf_pkg::LEVEL_W-1:0]  pend_level_reg;

    // output register
    logic                          m_valid_reg;
    logic [1:0]                    m_status_reg;
    logic [spmf_pkg::HANDLE_W-1:0] m_served_handle_reg;
    logic [spmf_pkg::LEVEL_W-1:0]  m_served_level_reg;
    logic                          m_queue_empty_reg;
    logic [spmf_pkg::HELD_W-1:0]   m_held_count_reg;

    logic [LIW-1:0]                en;
    logic [LIW-1:0]                lvl_ext;
    logic [LW-1:0]                 enq_idx;
    logic [LW-1:0]                 deq_idx;
    logic [LIW-1:0]                deq_idx_ext;
    logic                          deq_found;
    logic                          enq_ok;
    logic                          deq_ok;
    spmf_pkg::status_t             status_now;
    logic [LW-1:0]                 sel_idx;
    logic [PW-1:0]                 sel_ptr;
    logic [AW-1:0]                 mem_addr;
    logic [TXW-1:0]                total_ext;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        advance = (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        en      = (levels_in_use > LIW'(LEVELS)) ? LIW'(LEVELS) : levels_in_use;
        lvl_ext = LIW'(s_priority_level);
        enq_idx = lvl_ext[LW-1:0];

        // highest enabled non-empty level
        deq_found = 1'b0;
        deq_idx   = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (count_reg[i] != '0 && LIW'(i) < en) begin
                deq_found = 1'b1;
                deq_idx   = LW'(i);
            end
        end
        deq_idx_ext = LIW'(deq_idx);

        enq_ok     = 1'b0;
        deq_ok     = 1'b0;
        status_now = spmf_pkg::STATUS_OK;
        if (s_operation == spmf_pkg::OP_ENQUEUE) begin
            if (lvl_ext >= en) begin
                status_now = spmf_pkg::STATUS_UNUSED;
            end else if (count_reg[enq_idx] == CW'(LEVEL_DEPTH)) begin
                status_now = spmf_pkg::STATUS_FULL;
            end else begin
                enq_ok = 1'b1;
            end
        end else begin
            if (!deq_found) begin
                status_now = spmf_pkg::STATUS_EMPTY;
            end else begin
                deq_ok = 1'b1;
            end
        end

        sel_idx  = (s_operation == spmf_pkg::OP_ENQUEUE) ? enq_idx : deq_idx;
        sel_ptr  = (s_operation == spmf_pkg::OP_ENQUEUE) ? tail_reg[enq_idx]
                                                         : head_reg[deq_idx];
        mem_addr = AW'(int'(sel_idx) * LEVEL_DEPTH + int'(sel_ptr));
        total_ext = TXW'(total_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            total_reg <= '0;
        end else if (cmd.accept) begin
            if (enq_ok) begin
                tail_reg[enq_idx]  <= advance(tail_reg[enq_idx]);
                count_reg[enq_idx] <= count_reg[enq_idx] + 1'b1;
                total_reg          <= total_reg + 1'b1;
            end else if (deq_ok) begin
                head_reg[deq_idx]  <= advance(head_reg[deq_idx]);
                count_reg[deq_idx] <= count_reg[deq_idx] - 1'b1;
                total_reg          <= total_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && enq_ok) begin
            mem[mem_addr] <= s_item_handle[SW-1:0];
        end
        if (cmd.accept && deq_ok) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pend_status_reg <= status_now;
            pend_hit_reg    <= deq_ok;
            pend_level_reg  <= deq_ok ? deq_idx_ext[spmf_pkg::LEVEL_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg        <= pend_status_reg;
            m_served_handle_reg <= pend_hit_reg ? spmf_pkg::HANDLE_W'(rdata_reg) : '0;
            m_served_level_reg  <= pend_level_reg;
            m_queue_empty_reg   <= (total_reg == '0);
            m_held_count_reg    <= total_ext[spmf_pkg::HELD_W-1:0];
        end
    end

    assign dp_status.out_free = !m_valid_reg || m_ready;
    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_served_handle    = m_served_handle_reg;
    assign m_served_level     = m_served_level_reg;
    assign m_queue_empty      = m_queue_empty_reg;
    assign m_held_count       = m_held_count_reg;

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TW'(DEPTH))
        else $error("total held count beyond capacity");

    a_enq_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && enq_ok |=> total_reg == $past(total_reg) + 1'b1)
        else $error("accepted enqueue did not add to total");

    a_deq_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && deq_ok |=> total_reg == $past(total_reg) - 1'b1)
        else $error("served dequeue did not take from total");

    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out && pend_hit_reg |=> m_status_reg == spmf_pkg::STATUS_OK)
        else $error("served handle with a failing status");

endmodule

@@ hdl/strict_priority_multi_fifo.sv @@
// a result goes from the pending registers into the output register in the response state, once the slot is free
// each item passes one idle and one response state; a new item is taken only in the idle state
// a result waiting in the output register keeps the controller in the response state and holds off the next item
// reset: synchronous, active low; clears all level pointers, counts and the total,
// sets levels_in_use to LEVELS; the handle store is not cleared
module strict_priority_multi_fifo #(
    parameter int LEVELS      = 8,
    parameter int LEVEL_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel (levels_in_use)
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spmf_pkg::CFG_W-1:0]          cfg_data,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [spmf_pkg::HANDLE_W-1:0]       s_item_handle,
    input  logic [spmf_pkg::LEVEL_W-1:0]        s_priority_level,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [spmf_pkg::HANDLE_W-1:0]       m_served_handle,
    output logic [spmf_pkg::LEVEL_W-1:0]        m_served_level,
    output logic                                m_queue_empty,
    output logic [spmf_pkg::HELD_W-1:0]         m_held_count
);

    // register wide enough for the 4-bit write and for LEVELS itself
    localparam int LIW = ($clog2(LEVELS + 1) > spmf_pkg::CFG_W) ? $clog2(LEVELS + 1)
                                                                 : spmf_pkg::CFG_W;

    logic [LIW-1:0]        levels_in_use_reg;
    spmf_pkg::ctrl_cmd_t   cmd;
    spmf_pkg::dp_status_t  dp_status;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_in_use_reg <= LIW'(LEVELS);
        end else if (cfg_valid) begin
            levels_in_use_reg <= LIW'(cfg_data);
        end
    end

    // sequencer: idle -> response, waits there for a free output slot
    spmf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // level rings, priority pick, handle store and output register
    spmf_datapath #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .HANDLE_BITS (HANDLE_BITS),
        .LIW         (LIW)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .levels_in_use    (levels_in_use_reg),
        .cmd              (cmd),
        .dp_status        (dp_status),
        .s_operation      (s_operation),
        .s_item_handle    (s_item_handle),
        .s_priority_level (s_priority_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_served_handle  (m_served_handle),
        .m_served_level   (m_served_level),
        .m_queue_empty    (m_queue_empty),
        .m_held_count     (m_held_count)
    );

endmodule
